@@ rtl/sac_pkg.sv @@
// ----------------------------------------------------------------------------
// sac_pkg: shared types and constants
// Request and result formats, cache geometry and control structs for the
// set-associative write-back cache.
// ----------------------------------------------------------------------------
package sac_pkg;

  localparam int WAYS      = 8;
  localparam int SETS      = 256;
  localparam int BLOCK_W   = 30;
  localparam int WAY_W     = $clog2(WAYS);
  localparam int WCNT_W    = $clog2(WAYS + 1);
  localparam int SET_W     = $clog2(SETS);
  localparam int SCNT_W    = $clog2(SETS + 1);
  localparam int AGE_W     = $clog2(WAYS);
  localparam int DIV_STEPS = BLOCK_W / 2;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int WAYS_REG_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_WAYS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETS = 2'd1;

  localparam logic [WAYS_REG_W-1:0] WAYS_RST = WAYS_REG_W'(WAYS);
  localparam logic [CFG_DATA_W-1:0] SETS_RST = CFG_DATA_W'(SETS);

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;
  localparam logic MEM_RD    = 1'b0;
  localparam logic MEM_WB    = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [BLOCK_W-1:0] block;
  } req_t;

  typedef struct packed {
    logic               mem_op;
    logic [BLOCK_W-1:0] mem_block;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0]            dirty;
    logic [WAYS-1:0][AGE_W-1:0] age;
  } row_meta_t;

  typedef logic [WAYS-1:0][BLOCK_W-1:0] row_tag_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel;
    logic set_ld;
    logic ram_rd;
    logic update;
    logic emit_wb;
    logic emit_rd;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic hit;
    logic wb;
  } dp_stat_t;

endpackage

@@ rtl/sac_ram.sv @@
// ----------------------------------------------------------------------------
// sac_ram: generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sac_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/sac_div.sv @@
// ----------------------------------------------------------------------------
// sac_div: iterative divider
// Restoring division, two quotient bits per cycle; gives quotient and
// remainder of the block number by a small divisor.
// ----------------------------------------------------------------------------
module sac_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sac_pkg::BLOCK_W-1:0]   dvd,
  input  logic [sac_pkg::CFG_DATA_W-1:0] dvs,
  output logic [sac_pkg::BLOCK_W-1:0]   quo,
  output logic [sac_pkg::CFG_DATA_W-1:0] rem,
  output logic                          done
);
  import sac_pkg::*;

  logic [BLOCK_W-1:0]    quo_r, quo_nxt;
  logic [CFG_DATA_W-1:0] rem_r, rem_nxt;
  logic [CFG_DATA_W-1:0] dvs_r;
  logic [DCNT_W-1:0]     cnt_r;
  logic                  run_r, done_r;

  always_comb begin
    logic [CFG_DATA_W:0] r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    for (int i = 0; i < 2; i++) begin
      r       = {rem_nxt, quo_nxt[BLOCK_W-1]};
      quo_nxt = {quo_nxt[BLOCK_W-2:0], 1'b0};
      if (r >= {1'b0, dvs_r}) begin
        r          = r - {1'b0, dvs_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = r[CFG_DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
      quo_r  <= dvd;
      rem_r  <= '0;
      dvs_r  <= dvs;
    end else if (run_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(DIV_STEPS - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

@@ rtl/sac_dp.sv @@
// ----------------------------------------------------------------------------
// sac_dp: cache datapath
// Configuration, set index computation, tag and state rows, LRU update and
// result registers.
// ----------------------------------------------------------------------------
module sac_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sac_pkg::dp_cmd_t                cmd,
  output sac_pkg::dp_stat_t               stat,
  input  sac_pkg::req_t                   in_req,
  input  logic                            cfg_we,
  input  logic [sac_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [sac_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic                            out_strobe,
  output sac_pkg::res_t                   out_res
);
  import sac_pkg::*;

  logic [WAYS_REG_W-1:0] ways_r;
  logic [CFG_DATA_W-1:0] sets_r;
  logic [SETS-1:0]       row_ok_r;
  logic [BLOCK_W-1:0]    blk_r;
  logic                  wr_r;
  logic [SET_W-1:0]      set_r;
  logic                  out_strobe_r;
  res_t                  out_res_r;

  logic [WCNT_W-1:0]     nways;
  logic [CFG_DATA_W-1:0] nsets;
  logic [BLOCK_W-1:0]    div_quo;
  logic [CFG_DATA_W-1:0] div_rem;
  logic [BLOCK_W-1:0]    div_dvd;
  logic [CFG_DATA_W-1:0] div_dvs;
  logic                  div_done;

  logic [$bits(row_meta_t)-1:0] meta_raw;
  logic [$bits(row_tag_t)-1:0]  tag_raw;
  row_meta_t meta, meta_new;
  row_tag_t  tags, tags_new;
  logic      hit, free_found, wb;
  logic [WAY_W-1:0] hw, fw, vw, slot;

  always_comb begin
    if (ways_r == '0) begin
      nways = WCNT_W'(1);
    end else if (WCNT_W'(ways_r) > WCNT_W'(WAYS)) begin
      nways = WCNT_W'(WAYS);
    end else begin
      nways = WCNT_W'(ways_r);
    end
    if (sets_r == '0) begin
      nsets = CFG_DATA_W'(1);
    end else if (sets_r > CFG_DATA_W'(SETS)) begin
      nsets = CFG_DATA_W'(SETS);
    end else begin
      nsets = sets_r;
    end
  end

  assign div_dvd = cmd.div_sel ? div_quo : blk_r;
  assign div_dvs = cmd.div_sel ? nsets : CFG_DATA_W'(nways);

  sac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .quo   (div_quo),
    .rem   (div_rem),
    .done  (div_done)
  );

  sac_ram #(.W($bits(row_meta_t)), .D(SETS)) u_meta_ram (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (set_r),
    .wdata (meta_new),
    .re    (cmd.ram_rd),
    .raddr (set_r),
    .rdata (meta_raw)
  );

  sac_ram #(.W($bits(row_tag_t)), .D(SETS)) u_tag_ram (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (set_r),
    .wdata (tags_new),
    .re    (cmd.ram_rd),
    .raddr (set_r),
    .rdata (tag_raw)
  );

  always_comb begin
    logic [AGE_W-1:0] lim;
    logic             inc;
    meta       = row_ok_r[set_r] ? row_meta_t'(meta_raw) : '0;
    tags       = row_tag_t'(tag_raw);
    hit        = 1'b0;
    hw         = '0;
    free_found = 1'b0;
    fw         = '0;
    vw         = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (WCNT_W'(w) < nways && meta.valid[w] && tags[w] == blk_r && !hit) begin
        hit = 1'b1;
        hw  = WAY_W'(w);
      end
      if (WCNT_W'(w) < nways && !meta.valid[w] && !free_found) begin
        free_found = 1'b1;
        fw         = WAY_W'(w);
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (WCNT_W'(w) < nways && meta.age[w] > meta.age[vw]) begin
        vw = WAY_W'(w);
      end
    end
    slot = hit ? hw : (free_found ? fw : vw);
    wb   = !hit && !free_found && meta.dirty[vw];
    lim  = meta.age[hw];

    meta_new = meta;
    tags_new = tags;
    for (int w = 0; w < WAYS; w++) begin
      inc = hit ? (meta.age[w] < lim) : 1'b1;
      if (WCNT_W'(w) < nways && WAY_W'(w) != slot && meta.valid[w] && inc) begin
        meta_new.age[w] = meta.age[w] + 1'b1;
      end
    end
    meta_new.valid[slot] = 1'b1;
    meta_new.age[slot]   = '0;
    meta_new.dirty[slot] = hit ? (meta.dirty[slot] | wr_r) : wr_r;
    tags_new[slot]       = blk_r;
  end

  assign stat.div_done = div_done;
  assign stat.hit      = hit;
  assign stat.wb       = wb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_r   <= WAYS_RST;
      sets_r   <= SETS_RST;
      row_ok_r <= '0;
    end else if (cfg_we && (cfg_idx == REG_WAYS || cfg_idx == REG_SETS)) begin
      if (cfg_idx == REG_WAYS) begin
        ways_r <= cfg_wdata[WAYS_REG_W-1:0];
      end else begin
        sets_r <= cfg_wdata;
      end
      row_ok_r <= '0;
    end else if (cmd.update) begin
      row_ok_r[set_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      blk_r <= in_req.block;
      wr_r  <= (in_req.cmd == CMD_WRITE);
    end
    if (cmd.set_ld) begin
      set_r <= div_rem[SET_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit_wb | cmd.emit_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_wb) begin
      out_res_r.mem_op    <= MEM_WB;
      out_res_r.mem_block <= tags[vw];
      out_res_r.last      <= 1'b0;
    end else if (cmd.emit_rd) begin
      out_res_r.mem_op    <= MEM_RD;
      out_res_r.mem_block <= blk_r;
      out_res_r.last      <= 1'b1;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

@@ rtl/sac_ctrl.sv @@
// ----------------------------------------------------------------------------
// sac_ctrl: cache controller
// Sequences set index division, row read, update and result emission.
// ----------------------------------------------------------------------------
module sac_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sac_pkg::dp_stat_t  stat,
  output sac_pkg::dp_cmd_t   cmd
);
  import sac_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVA_GO,
    S_DIVA,
    S_DIVB,
    S_RD,
    S_EVAL,
    S_OUT_RD
  } state_t;

  state_t state_r;

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load = start;
      end
      S_DIVA_GO: begin
        cmd.div_start = 1'b1;
      end
      S_DIVA: begin
        cmd.div_start = stat.div_done;
        cmd.div_sel   = 1'b1;
      end
      S_DIVB: begin
        cmd.set_ld = stat.div_done;
      end
      S_RD: begin
        cmd.ram_rd = 1'b1;
      end
      S_EVAL: begin
        cmd.update  = 1'b1;
        cmd.emit_wb = !stat.hit && stat.wb;
        cmd.emit_rd = !stat.hit && !stat.wb;
      end
      S_OUT_RD: begin
        cmd.emit_rd = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) state_r <= S_DIVA_GO;
        end
        S_DIVA_GO: state_r <= S_DIVA;
        S_DIVA: begin
          if (stat.div_done) state_r <= S_DIVB;
        end
        S_DIVB: begin
          if (stat.div_done) state_r <= S_RD;
        end
        S_RD:   state_r <= S_EVAL;
        S_EVAL: begin
          if (!stat.hit && stat.wb) begin
            state_r <= S_OUT_RD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_OUT_RD: state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ rtl/set_assoc_writeback_lru_cache.sv @@
// ----------------------------------------------------------------------------
// set_assoc_writeback_lru_cache: set-associative write-back LRU cache
// One request at a time, busy until it is done: accept, divider start, two
// divider passes (block / ways, then mod sets; 15 steps plus a done strobe
// each), row read and update. A miss gives its registered memory read
// strobe; a dirty eviction gives its write-back first and the read in the
// cycle after. Synchronous reset and a write to the ways or sets register
// invalidate all lines at once through per-set flags.
// ----------------------------------------------------------------------------
module set_assoc_writeback_lru_cache (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  sac_pkg::req_t                   in_req,
  output logic                            out_strobe,
  output sac_pkg::res_t                   out_res,
  input  logic                            cfg_we,
  input  logic [sac_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [sac_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import sac_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sac_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  sac_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_req     (in_req),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule

@@ dv/sac_checker.sv @@
// ----------------------------------------------------------------------------
// sac_checker: cache miss traffic predictor and scoreboard
// Watches accepted requests and register writes, keeps its own copy of the
// tag store and LRU ranks, queues the expected memory transactions and
// compares each result strobe against the oldest one.
// ----------------------------------------------------------------------------
module sac_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  sac_pkg::req_t                  in_req,
  input  logic                           out_strobe,
  input  sac_pkg::res_t                  out_res,
  input  logic                           cfg_we,
  input  logic [sac_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [sac_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             errors,
  output int                             pending
);
  import sac_pkg::*;

  localparam int LINES = WAYS * SETS;

  logic [WAYS_REG_W-1:0] ways_reg;
  logic [CFG_DATA_W-1:0] sets_reg;
  bit                    line_vld   [LINES];
  logic [BLOCK_W-1:0]    line_tag   [LINES];
  bit                    line_drt   [LINES];
  int                    line_rank  [LINES];
  res_t                  mem_traffic[$];

  function automatic void flush_lines();
    for (int i = 0; i < LINES; i++) begin
      line_vld[i]  = 0;
      line_drt[i]  = 0;
      line_rank[i] = 0;
      line_tag[i]  = '0;
    end
  endfunction

  function automatic void make_recent(int base, int nw, int hit, int limit);
    for (int w = 0; w < nw; w++) begin
      if (w != hit && line_vld[base + w] && line_rank[base + w] < limit)
        line_rank[base + w]++;
    end
    line_rank[base + hit] = 0;
  endfunction

  function automatic void lookup(req_t r);
    int   nw, ns, base, slot, victim;
    bit   found;
    res_t t;
    nw = (ways_reg == 0) ? 1 : (ways_reg > WAYS) ? WAYS : int'(ways_reg);
    ns = (sets_reg == 0) ? 1 : (sets_reg > SETS) ? SETS : int'(sets_reg);
    base = ((int'(r.block) / nw) % ns) * WAYS;
    for (int w = 0; w < nw; w++) begin
      if (line_vld[base + w] && line_tag[base + w] == r.block) begin
        make_recent(base, nw, w, line_rank[base + w]);
        if (r.cmd == CMD_WRITE) line_drt[base + w] = 1;
        return;
      end
    end
    found = 0;
    slot  = 0;
    for (int w = 0; w < nw; w++) begin
      if (!found && !line_vld[base + w]) begin
        slot  = w;
        found = 1;
      end
    end
    if (!found) begin
      victim = 0;
      for (int w = 1; w < nw; w++)
        if (line_rank[base + w] > line_rank[base + victim]) victim = w;
      slot = victim;
      if (line_drt[base + slot]) begin
        t.mem_op    = MEM_WB;
        t.mem_block = line_tag[base + slot];
        t.last      = 1'b0;
        mem_traffic.push_back(t);
      end
      line_vld[base + slot] = 0;
    end
    make_recent(base, nw, slot, 255);
    line_vld[base + slot] = 1;
    line_tag[base + slot] = r.block;
    line_drt[base + slot] = (r.cmd == CMD_WRITE);
    t.mem_op    = MEM_RD;
    t.mem_block = r.block;
    t.last      = 1'b1;
    mem_traffic.push_back(t);
  endfunction

  always @(posedge clk) begin
    res_t e;
    if (!rst_n) begin
      ways_reg = WAYS_RST;
      sets_reg = SETS_RST;
      flush_lines();
      mem_traffic.delete();
    end else begin
      if (out_strobe) begin
        if (mem_traffic.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: op=%0d block=%h last=%0d",
                     out_res.mem_op, out_res.mem_block, out_res.last);
        end else begin
          e = mem_traffic.pop_front();
          if (e.mem_op !== out_res.mem_op || e.mem_block !== out_res.mem_block ||
              e.last !== out_res.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp op=%0d block=%h last=%0d, got op=%0d block=%h last=%0d",
                       e.mem_op, e.mem_block, e.last,
                       out_res.mem_op, out_res.mem_block, out_res.last);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_idx == REG_WAYS) begin
          ways_reg = cfg_wdata[WAYS_REG_W-1:0];
          flush_lines();
        end else if (cfg_idx == REG_SETS) begin
          sets_reg = cfg_wdata;
          flush_lines();
        end
      end
      if (start && !busy) lookup(in_req);
    end
    pending = mem_traffic.size();
  end

  initial begin
    errors  = 0;
    pending = 0;
  end

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench top for the set-associative write-back LRU cache
// Drives directed and random read/write requests over several cache
// geometries, with random idle bursts; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import sac_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 60;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  req_t                  in_req;
  logic                  out_strobe;
  res_t                  out_res;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    errors;
  int                    pending;
  int                    quiet_cycles;
  bit                    no_idle;
  logic [BLOCK_W-1:0]    recent_blocks[$];

  set_assoc_writeback_lru_cache dut (.*);

  sac_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send(logic cmd, logic [BLOCK_W-1:0] blk);
    start        <= 1'b1;
    in_req.cmd   <= cmd;
    in_req.block <= blk;
    do @(posedge clk); while (busy);
    recent_blocks.push_back(blk);
    if (recent_blocks.size() > 12) void'(recent_blocks.pop_front());
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    recent_blocks.delete();
  endtask

  function automatic logic [BLOCK_W-1:0] pick_block();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return recent_blocks.size() != 0 ?
                    recent_blocks[$urandom_range(0, recent_blocks.size() - 1)] : '0;
      4, 5, 6:    return BLOCK_W'($urandom_range(0, 63));
      7:          return BLOCK_W'($urandom_range(0, 15) * 2048 + $urandom_range(0, 7));
      default:    return BLOCK_W'($urandom());
    endcase
  endfunction

  task automatic random_run(int count);
    for (int i = 0; i < count; i++)
      send(logic'($urandom_range(0, 1)), pick_block());
  endtask

  initial begin
    rst_n     = 0;
    start     = 0;
    in_req    = '0;
    cfg_we    = 0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    no_idle   = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default geometry, then a single two-way set
    send(CMD_WRITE, '0);
    send(CMD_READ,  '0);
    send(CMD_READ,  '1);
    send(CMD_WRITE, '1);
    for (int k = 1; k <= 8; k++) send(CMD_WRITE, BLOCK_W'(k * 2048));
    send(CMD_READ, 30'h2AAAAAAA);
    send(CMD_READ, 30'h15555555);
    drain();
    write_reg(REG_WAYS, 9'd2);
    write_reg(REG_SETS, 9'd1);
    send(CMD_WRITE, 30'd0);
    send(CMD_READ,  30'd1);
    send(CMD_READ,  30'd0);
    send(CMD_READ,  30'd5);
    send(CMD_WRITE, 30'd6);
    send(CMD_READ,  30'd0);
    send(CMD_WRITE, 30'd6);
    send(CMD_READ,  30'd9);
    drain();

    write_reg(REG_SPARE_LO, 9'h1FF);
    random_run(40);
    drain();
    write_reg(REG_WAYS, 9'd0);
    write_reg(REG_SETS, 9'd0);
    random_run(60);
    drain();
    write_reg(REG_WAYS, 9'd15);
    write_reg(REG_SETS, 9'h1FF);
    random_run(70);
    drain();
    write_reg(REG_WAYS, 9'd3);
    write_reg(REG_SETS, 9'd5);
    random_run(80);
    drain();
    write_reg(REG_WAYS, 9'd1);
    write_reg(REG_SETS, 9'd2);
    write_reg(REG_SPARE_HI, 9'd0);
    random_run(60);
    drain();
    write_reg(REG_WAYS, 9'd8);
    write_reg(REG_SETS, 9'd256);
    random_run(80);
    drain();
    write_reg(REG_WAYS, 9'd4);
    write_reg(REG_SETS, 9'd3);
    random_run(30);
    no_idle = 1;
    random_run(60);
    drain();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
